@@ rtl/core/integer_to_ascii_formatter_macros.svh @@
// assertion macros for the integer to ascii formatter checker
// each macro expects clock and reset to be visible in the using scope
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ITAF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("itaf same-cycle property failed");

// consequent must hold in the cycle after the antecedent
`define ITAF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("itaf next-cycle property failed");

`endif

@@ rtl/core/itaf_pkg.sv @@
package itaf_pkg;

   // operand width actually formatted, the low bits of the value field
   localparam int VALUE_BITS = 64;
   localparam int FIELD_W    = 64;
   localparam int MODE_W     = 2;
   localparam int CHAR_W     = 7;

   // decimal digits: floor(bits * log10(2)) + 1, slightly overestimated
   localparam int DEC_DIGITS = (VALUE_BITS * 78) / 256 + 1;
   localparam int DEC_W      = DEC_DIGITS * 4;
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int HEX_W      = HEX_DIGITS * 4;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);

   localparam logic [MODE_W-1:0] MODE_UDEC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SDEC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HEX  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [FIELD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } rsp_type;

   // ascii for one hex or decimal digit, upper case letters
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] code;
      if (nib < 4'd10) begin
         code = CHAR_ZERO + {3'b000, nib};
      end else begin
         code = CHAR_A + {3'b000, nib} - 7'd10;
      end
      return code;
   endfunction

endpackage

@@ rtl/core/integer_to_ascii_formatter.sv @@
// integer to ascii formatter
// request channel: start / busy command handshake. an item (mode, value) is
// taken at a rising edge where start is high and busy is low. busy stays high
// for the whole time the item is being worked on.
// response channel: rsp_valid strobes for one cycle per character, most
// significant character first; last_char marks the final character of the item.
// the receiver cannot stall, so characters simply stream out as produced.
// mode 0 (and the unused code 3): unsigned decimal, no leading zeros.
// mode 1: signed decimal, '-' then the magnitude. mode 2: "0x" plus HEX_DIGITS
// upper-case hex digits.
// decimal path: one shift-add-3 step per cycle over the binary operand,
// then one digit slot per cycle over DEC_DIGITS slots, leading zeros
// skipped silently. busy is high for all of an item but its accept cycle.
// hex path: one character per cycle.
// a new item can be accepted in the cycle the last character is on the port.
// reset returns to idle and drops any item in flight; no state spans items.
module integer_to_ascii_formatter (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  itaf_pkg::req_type req_payload,
   output logic            rsp_valid,
   output itaf_pkg::rsp_type rsp_payload
);
   import itaf_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_DEC  = 3'd2;
   localparam logic [2:0] ST_PREX = 3'd3;
   localparam logic [2:0] ST_HEX  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  started_ff, started_in;
   logic [DEC_W-1:0]      sh_ff, sh_in;        // bcd digits, or hex nibbles
   logic [VALUE_BITS-1:0] bin_ff, bin_in;      // binary operand being shifted out
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_payload_ff, rsp_payload_in;

   logic [VALUE_BITS-1:0] value_masked;
   logic                  is_neg;
   logic [VALUE_BITS-1:0] magnitude;
   logic [DEC_W-1:0]      bcd_adj;
   logic [3:0]            top_nib;
   logic                  cnt_last;

   assign value_masked = req_payload.value[VALUE_BITS-1:0];
   assign is_neg       = (req_payload.mode == MODE_SDEC) && value_masked[VALUE_BITS-1];
   // two's complement magnitude; the most negative value maps onto itself,
   // which read unsigned is the right magnitude
   assign magnitude    = is_neg ? ('0 - value_masked) : value_masked;
   assign top_nib      = sh_ff[DEC_W-1 -: 4];
   assign cnt_last     = (cnt_ff == CNT_W'(1));

   // add 3 to every bcd digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (sh_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = sh_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = sh_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      started_in     = started_ff;
      sh_in          = sh_ff;
      bin_in         = bin_ff;
      rsp_valid_in   = 1'b0;
      rsp_payload_in = rsp_payload_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_payload.mode == MODE_HEX) begin
                  // nibbles sit at the top of the shift register
                  sh_in                    = DEC_W'(value_masked) << (DEC_W - HEX_W);
                  rsp_valid_in             = 1'b1;
                  rsp_payload_in.char_code = CHAR_ZERO;
                  rsp_payload_in.last_char = 1'b0;
                  state_in                 = ST_PREX;
               end else begin
                  bin_in   = magnitude;
                  sh_in    = '0;
                  cnt_in   = CNT_W'(VALUE_BITS);
                  state_in = ST_CONV;
                  // sign goes out right away, a negative magnitude is never zero
                  if (is_neg) begin
                     rsp_valid_in             = 1'b1;
                     rsp_payload_in.char_code = CHAR_MINUS;
                     rsp_payload_in.last_char = 1'b0;
                  end
               end
            end
         end
         ST_PREX: begin
            rsp_valid_in             = 1'b1;
            rsp_payload_in.char_code = CHAR_X;
            rsp_payload_in.last_char = 1'b0;
            cnt_in                   = CNT_W'(HEX_DIGITS);
            state_in                 = ST_HEX;
         end
         ST_HEX: begin
            rsp_valid_in             = 1'b1;
            rsp_payload_in.char_code = digit_char(top_nib);
            rsp_payload_in.last_char = cnt_last;
            sh_in                    = sh_ff << 4;
            cnt_in                   = cnt_ff - CNT_W'(1);
            if (cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_CONV: begin
            // one double-dabble step per cycle
            sh_in  = {bcd_adj[DEC_W-2:0], bin_ff[VALUE_BITS-1]};
            bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_last) begin
               cnt_in     = CNT_W'(DEC_DIGITS);
               started_in = 1'b0;
               state_in   = ST_DEC;
            end
         end
         ST_DEC: begin
            // leading zeros are skipped, the final digit always goes out
            if ((top_nib != 4'd0) || started_ff || cnt_last) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.char_code = digit_char(top_nib);
               rsp_payload_in.last_char = cnt_last;
               started_in               = 1'b1;
            end
            sh_in  = sh_ff << 4;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      sh_ff          <= sh_in;
      bin_ff         <= bin_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ rtl/core/itaf_checker.sv @@
`include "integer_to_ascii_formatter_macros.svh"

module itaf_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input itaf_pkg::req_type req_payload,
   input logic              rsp_valid,
   input itaf_pkg::rsp_type rsp_payload
);
   import itaf_pkg::*;

   logic accept;
   logic char_ok;

   assign accept  = start && !busy;
   assign char_ok = ((rsp_payload.char_code >= CHAR_ZERO)
                       && (rsp_payload.char_code <= CHAR_ZERO + 7'd9))
                 || ((rsp_payload.char_code >= CHAR_A)
                       && (rsp_payload.char_code <= CHAR_A + 7'd5))
                 || (rsp_payload.char_code == CHAR_MINUS)
                 || (rsp_payload.char_code == CHAR_X);

   // every accepted item makes the block busy in the cycle after the accept
   `ITAF_ASSERT_NEXT(a_accept_busy, accept, busy)
   // the final character ends the item
   `ITAF_ASSERT_NOW(a_last_idle, rsp_valid && rsp_payload.last_char, !busy)
   // characters other than the final one come while the item is still open
   `ITAF_ASSERT_NOW(a_mid_busy, rsp_valid && !rsp_payload.last_char, busy)
   // hex items open with the zero of the prefix
   `ITAF_ASSERT_NEXT(a_hex_prefix, accept && (req_payload.mode == MODE_HEX),
      rsp_valid && (rsp_payload.char_code == CHAR_ZERO) && !rsp_payload.last_char)
   // only digits, hex letters, sign and the x of the prefix are produced
   `ITAF_ASSERT_NOW(a_char_set, rsp_valid, char_ok)

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import itaf_pkg::*;

   // mode code 3 has no meaning of its own, the block treats it as unsigned decimal
   localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

   // digit glyphs, first character in the top byte
   localparam logic [127:0] HEX_TABLE = "0123456789ABCDEF";

   // watchdog limit on the whole run, with a wide margin over the worst case
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 450;
   // no sender idling once this few items are left to send
   localparam int QUIET_TAIL   = 60;
   localparam int REPORT_MAX   = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_valid;
   rsp_type rsp_payload;

   req_type pending_items[$];
   rsp_type expected_chars[$];
   rsp_type wanted_char;
   int      gap_left       = 0;
   int      accepted_count = 0;
   int      mismatch_count = 0;
   int      cycle_count    = 0;

   integer_to_ascii_formatter i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // text of one item, most significant character first, last flag on the tail
   function automatic void predict_text(input req_type item);
      logic [CHAR_W-1:0]  text[$];
      logic [CHAR_W-1:0]  digits[$];
      logic [FIELD_W-1:0] mask;
      logic [FIELD_W-1:0] operand;
      logic [FIELD_W-1:0] magnitude;
      logic [FIELD_W-1:0] remainder;
      logic [3:0]         nib;
      rsp_type            ch;
      mask = (VALUE_BITS >= FIELD_W) ? {FIELD_W{1'b1}}
                                     : ((64'd1 << VALUE_BITS) - 64'd1);
      operand   = item.value & mask;
      magnitude = operand;
      if (item.mode == MODE_HEX) begin
         text.push_back(CHAR_ZERO);
         text.push_back(CHAR_X);
         for (int d = HEX_DIGITS - 1; d >= 0; d--) begin
            nib = operand[d*4 +: 4];
            text.push_back(HEX_TABLE[(15 - int'(nib)) * 8 +: CHAR_W]);
         end
      end else begin
         // signed mode: sign bit set means '-' and the two's complement magnitude
         if (item.mode == MODE_SDEC && operand[VALUE_BITS-1]) begin
            text.push_back(CHAR_MINUS);
            magnitude = (~operand + 64'd1) & mask;
         end
         // zero still prints a single digit
         if (magnitude == 0) begin
            digits.push_back(CHAR_ZERO);
         end
         while (magnitude != 0) begin
            remainder = magnitude % 64'd10;
            digits.push_front(CHAR_ZERO + remainder[CHAR_W-1:0]);
            magnitude = magnitude / 64'd10;
         end
         foreach (digits[i]) text.push_back(digits[i]);
      end
      foreach (text[i]) begin
         ch.char_code = text[i];
         ch.last_char = (i == text.size() - 1);
         expected_chars.push_back(ch);
      end
   endfunction

   // random item with the value shaped toward digit-count edges and small magnitudes
   function automatic req_type random_item();
      req_type     item;
      logic [63:0] p;
      int          sel;
      sel = $urandom_range(0, 9);
      if (sel < 3)      item.mode = MODE_UDEC;
      else if (sel < 7) item.mode = MODE_SDEC;
      else if (sel < 9) item.mode = MODE_HEX;
      else              item.mode = MODE_RSVD;
      case ($urandom_range(0, 4))
         0: item.value = {$urandom, $urandom};
         1: item.value = 64'($urandom_range(0, 99));
         2: item.value = {$urandom, $urandom} >> $urandom_range(0, 63);
         3: begin
            // one below, at or one above a power of ten
            p = 64'd1;
            repeat ($urandom_range(0, 19)) p = p * 64'd10;
            item.value = p + 64'($urandom_range(0, 2)) - 64'd1;
         end
         default: item.value = 64'd0 - 64'($urandom_range(1, 200));
      endcase
      return item;
   endfunction

   task automatic queue_request(input logic [MODE_W-1:0] mode, input logic [63:0] value);
      req_type item;
      item.mode  = mode;
      item.value = value;
      pending_items.push_back(item);
   endtask

   task automatic note_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
   endtask

   // driver: whenever start is high the head of pending_items is on the port
   always @(posedge clock) begin
      if (reset) begin
         start       <= 1'b0;
         req_payload <= '0;
         gap_left    =  0;
      end else begin
         if (start && !busy) begin
            predict_text(req_payload);
            void'(pending_items.pop_front());
            accepted_count++;
         end
         if (gap_left > 0) begin
            // inside an idle burst, junk on the payload while start is low
            gap_left--;
            start       <= 1'b0;
            req_payload <= random_item();
         end else if (pending_items.size() > QUIET_TAIL && (accepted_count / 40) % 2 == 0
                      && $urandom_range(0, 15) == 0) begin
            // idle bursts only in alternate stretches of 40 items, can land at any
            // point of the block's work
            gap_left    =  $urandom_range(1, 14) - 1;
            start       <= 1'b0;
            req_payload <= random_item();
         end else if (pending_items.size() != 0) begin
            start       <= 1'b1;
            req_payload <= pending_items[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed character must match the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_chars.size() == 0) begin
            note_error($sformatf("unexpected char %h last %b with nothing pending",
                                 rsp_payload.char_code, rsp_payload.last_char));
         end else begin
            wanted_char = expected_chars.pop_front();
            if (rsp_payload.char_code !== wanted_char.char_code
                || rsp_payload.last_char !== wanted_char.last_char) begin
               note_error($sformatf("expected char %h last %b, got char %h last %b",
                                    wanted_char.char_code, wanted_char.last_char,
                                    rsp_payload.char_code, rsp_payload.last_char));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      // directed: zero, single digits, digit-count edges, extremes of every mode
      queue_request(MODE_UDEC, 64'd0);
      queue_request(MODE_UDEC, 64'd9);
      queue_request(MODE_UDEC, 64'd10);
      queue_request(MODE_UDEC, 64'd9999999999999999999);
      queue_request(MODE_UDEC, 64'd10000000000000000000);
      queue_request(MODE_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
      // signed zero prints without sign, most negative value comes out exact
      queue_request(MODE_SDEC, 64'd0);
      queue_request(MODE_SDEC, 64'd1);
      queue_request(MODE_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_request(MODE_SDEC, 64'hFFFF_FFFF_FFFF_FFF6);
      queue_request(MODE_SDEC, 64'h8000_0000_0000_0000);
      queue_request(MODE_SDEC, 64'h7FFF_FFFF_FFFF_FFFF);
      queue_request(MODE_HEX,  64'd0);
      queue_request(MODE_HEX,  64'hFFFF_FFFF_FFFF_FFFF);
      queue_request(MODE_HEX,  64'h0123_4567_89AB_CDEF);
      queue_request(MODE_HEX,  64'hFEDC_BA98_7654_3210);
      // unused mode code falls back to unsigned decimal
      queue_request(MODE_RSVD, 64'd0);
      queue_request(MODE_RSVD, 64'd12345);
      queue_request(MODE_RSVD, 64'hFFFF_FFFF_FFFF_FFFF);
      repeat (RANDOM_ITEMS) pending_items.push_back(random_item());

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      // room for any stray character after the last expected one
      repeat (120) @(posedge clock);

      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
